// File: hdl/tmhq_pkg.sv
// ----------------------------------------------------------------------------
// tmhq_pkg: shared types and codes for the timer min-heap queue
// Request kinds, result status codes and default sizes.
// ----------------------------------------------------------------------------
package tmhq_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int TAG_BITS_DEF  = 16;

  localparam logic [1:0] REQ_SCHED  = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_CHANGE = 2'd2;
  localparam logic [1:0] REQ_ADV    = 2'd3;

  localparam logic [2:0] ST_SCHED   = 3'd0;
  localparam logic [2:0] ST_FIRED   = 3'd1;
  localparam logic [2:0] ST_UPDATED = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

endpackage

// File: hdl/timer_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// timer_min_heap_queue_top: timer event queue on a binary min-heap
// Keeps entries ordered on (deadline, handle); schedule, cancel, change and
// advance requests are worked through a small sequencer and one compare unit.
// ----------------------------------------------------------------------------
// Schedule takes the lowest free handle, scanned one per cycle, and sifts the new
// entry up; cancel and change sift the moved entry up or down; advance removes
// and answers each fired entry in turn.
// A full queue or an unknown handle is answered in the next cycle, busy stays low.
// One request at a time; busy falls in the cycle that carries the last result word.
// Reset (synchronous, rst_n low) empties the queue and zeroes the time.
module timer_min_heap_queue_top #(
  parameter int DEPTH     = tmhq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = tmhq_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = tmhq_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic signed [31:0] in_delay,
  input  logic [5:0]  in_handle,
  input  logic [15:0] in_payload,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_out_handle,
  output logic [15:0] out_out_payload,
  output logic [31:0] out_out_deadline,
  output logic        out_last
);
  import tmhq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = TIME_BITS;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_CHG   = 4'd2;  // pos/tag read done, read entry
  localparam logic [3:0] S_CHG2  = 4'd3;
  localparam logic [3:0] S_TAIL  = 4'd4;  // tail entry arrives for the hole
  localparam logic [3:0] S_UP    = 4'd5;  // read parent
  localparam logic [3:0] S_UPCMP = 4'd6;
  localparam logic [3:0] S_DNL   = 4'd7;  // read left child
  localparam logic [3:0] S_DNR   = 4'd8;  // read right child
  localparam logic [3:0] S_DNCMP = 4'd9;  // pick the smaller child
  localparam logic [3:0] S_DNMV  = 4'd10; // child against working entry
  localparam logic [3:0] S_PLACE = 4'd11;
  localparam logic [3:0] S_ADV   = 4'd12; // read root
  localparam logic [3:0] S_ADV2  = 4'd13;
  localparam logic [3:0] S_FIRE  = 4'd14;

  // heap storage: deadline + owner per node; handle maps
  logic [TW-1:0]       hd_mem [DEPTH];
  logic [AW-1:0]       ho_mem [DEPTH];
  logic [AW-1:0]       pos_mem [DEPTH];
  logic [TAG_BITS-1:0] tag_mem [DEPTH];
  logic [DEPTH-1:0]    valid_r, valid_nxt;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [31:0]   dly_r, dly_nxt;
  logic [5:0]    hreq_r, hreq_nxt;
  logic [TAG_BITS-1:0] tagin_r, tagin_nxt;

  // working entry being sifted (held outside the heap until placed)
  logic [TW-1:0] wd_r, wd_nxt;
  logic [AW-1:0] wo_r, wo_nxt;
  logic [AW-1:0] p_r, p_nxt;          // current hole
  // best child tracked during sift-down
  logic [TW-1:0] cd_r, cd_nxt;
  logic [AW-1:0] co_r, co_nxt, cp_r, cp_nxt;
  logic          chave_r, chave_nxt;  // right child was read
  logic          moved_r, moved_nxt;  // moved up at least once
  logic          fired_r, fired_nxt;  // advance: a fired word is pending
  logic [AW:0]   scan_r, scan_nxt;

  // result word
  logic          ov_r, ov_nxt, ol_r, ol_nxt;
  logic [2:0]    os_r, os_nxt;
  logic [5:0]    oh_r, oh_nxt;
  logic [15:0]   op_r, op_nxt;
  logic [31:0]   odl_r, odl_nxt;

  // one read port and one write port, registered read
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [TW-1:0] rd_d;
  logic [AW-1:0] rd_o;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_d;
  logic [AW-1:0] wr_o;
  logic [AW-1:0] pos_rd;
  logic [TAG_BITS-1:0] tag_rd;
  logic [AW-1:0] pos_raddr;
  logic          tag_we;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hd_mem[wr_addr] <= wr_d;
      ho_mem[wr_addr] <= wr_o;
      pos_mem[wr_o]   <= wr_addr;
    end
    if (rd_en) begin
      rd_d <= hd_mem[rd_addr];
      rd_o <= ho_mem[rd_addr];
    end
    if (tag_we) tag_mem[scan_r[AW-1:0]] <= tagin_r;
    pos_rd <= pos_mem[pos_raddr];
    tag_rd <= tag_mem[pos_raddr];
  end

  // shared compare unit: (a_d,a_o) strictly before (b_d,b_o)
  logic [TW-1:0] cmp_ad, cmp_bd;
  logic [AW-1:0] cmp_ao, cmp_bo;
  logic          cmp_lt;
  assign cmp_lt = (cmp_ad < cmp_bd) || ((cmp_ad == cmp_bd) && (cmp_ao < cmp_bo));

  // saturating add of signed delay
  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] t,
                                            input logic [31:0] d);
    logic [TW+32:0] s;
    begin
      s = {{33{1'b0}}, t} + {{(TW+1){d[31]}}, d};
      if (s[TW+32])                 sat_add = '0;
      else if (|s[TW+31:TW])        sat_add = TMAX;
      else                          sat_add = s[TW-1:0];
    end
  endfunction

  // one shared adder: base is the time for schedule, the old deadline for change
  logic [TW-1:0] sat_base, sat_q;
  assign sat_base = (state_r == S_SCAN) ? now_r : rd_d;
  assign sat_q    = sat_add(sat_base, dly_r);

  logic [AW-1:0] par, lch, rch;
  logic [AW+1:0] lchw, rchw;
  assign par  = AW'((p_r - 1'b1) >> 1);
  assign lchw = {1'b0, p_r, 1'b1};
  assign rchw = lchw + 1'b1;
  assign lch  = lchw[AW-1:0];
  assign rch  = rchw[AW-1:0];

  assign busy = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_out_handle   = oh_r;
  assign out_out_payload  = op_r;
  assign out_out_deadline = odl_r;
  assign out_last         = ol_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; now_nxt = now_r;
    req_nxt = req_r; dly_nxt = dly_r; hreq_nxt = hreq_r; tagin_nxt = tagin_r;
    wd_nxt = wd_r; wo_nxt = wo_r; p_nxt = p_r;
    cd_nxt = cd_r; co_nxt = co_r; cp_nxt = cp_r; chave_nxt = chave_r;
    moved_nxt = moved_r; fired_nxt = fired_r; scan_nxt = scan_r;
    valid_nxt = valid_r;
    ov_nxt = 1'b0; ol_nxt = 1'b1; os_nxt = os_r; oh_nxt = oh_r;
    op_nxt = op_r; odl_nxt = odl_r;
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = p_r; wr_d = wd_r; wr_o = wo_r;
    tag_we = 1'b0; pos_raddr = hreq_r[AW-1:0];
    cmp_ad = wd_r; cmp_ao = wo_r; cmp_bd = rd_d; cmp_bo = rd_o;
    unique case (state_r)
      S_IDLE: begin
        pos_raddr = in_handle[AW-1:0];
        if (start) begin
          req_nxt = in_req_type; dly_nxt = in_delay; hreq_nxt = in_handle;
          tagin_nxt = TAG_BITS'(in_payload);
          fired_nxt = 1'b0; scan_nxt = '0;
          unique case (in_req_type) inside
            REQ_SCHED: begin
              if (count_r == CW'(DEPTH)) begin
                ov_nxt = 1'b1; os_nxt = ST_FULL; oh_nxt = '0; op_nxt = '0;
                odl_nxt = '0;
              end else state_nxt = S_SCAN;
            end
            REQ_CANCEL, REQ_CHANGE: begin
              if ((32'(in_handle) >= 32'(DEPTH)) || !valid_r[in_handle[AW-1:0]]) begin
                ov_nxt = 1'b1; os_nxt = ST_UNKNOWN; oh_nxt = in_handle;
                op_nxt = '0; odl_nxt = '0;
              end else state_nxt = S_CHG;
            end
            default: begin
              now_nxt = TW'(in_now_time);
              state_nxt = S_ADV;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!valid_r[scan_r[AW-1:0]]) begin
          valid_nxt[scan_r[AW-1:0]] = 1'b1;
          tag_we = 1'b1;
          wd_nxt = sat_q;
          wo_nxt = scan_r[AW-1:0];
          p_nxt = count_r[AW-1:0];
          count_nxt = count_r + 1'b1;
          moved_nxt = 1'b0;
          os_nxt = ST_SCHED; oh_nxt = 6'(scan_r[AW-1:0]);
          op_nxt = 16'(tagin_r); odl_nxt = 32'(sat_q);
          state_nxt = S_UP;
        end else scan_nxt = scan_r + 1'b1;
      end
      S_CHG: begin
        p_nxt = pos_rd; rd_en = 1'b1; rd_addr = pos_rd;
        op_nxt = 16'(tag_rd); oh_nxt = hreq_r; os_nxt = ST_UPDATED;
        state_nxt = S_CHG2;
      end
      S_CHG2: begin
        if (req_r == REQ_CANCEL) begin
          odl_nxt = 32'(rd_d);
          valid_nxt[rd_o] = 1'b0;
          count_nxt = count_r - 1'b1;
          rd_en = 1'b1; rd_addr = AW'(count_r - 1'b1);
          state_nxt = S_TAIL;
        end else begin
          wd_nxt = sat_q; wo_nxt = rd_o; odl_nxt = 32'(sat_q);
          moved_nxt = 1'b0;
          state_nxt = S_UP;
        end
      end
      S_TAIL: begin
        if (req_r == REQ_ADV) op_nxt = 16'(tag_rd);
        if (CW'(p_r) == count_r) begin
          // removed entry was the tail: nothing to move
          if (req_r == REQ_ADV) state_nxt = S_ADV;
          else begin
            ov_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end else begin
          wd_nxt = rd_d; wo_nxt = rd_o; moved_nxt = 1'b0;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (p_r == '0) begin
          state_nxt = moved_r ? S_PLACE : S_DNL;
        end else begin
          rd_en = 1'b1; rd_addr = par; state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (cmp_lt) begin
          wr_en = 1'b1; wr_addr = p_r; wr_d = rd_d; wr_o = rd_o;
          p_nxt = par; moved_nxt = 1'b1;
          state_nxt = S_UP;
        end else begin
          state_nxt = moved_r ? S_PLACE : S_DNL;
        end
      end
      S_DNL: begin
        if (lchw < (AW+2)'(count_r)) begin
          rd_en = 1'b1; rd_addr = lch; state_nxt = S_DNR;
        end else state_nxt = S_PLACE;
      end
      S_DNR: begin
        cd_nxt = rd_d; co_nxt = rd_o; cp_nxt = lch;
        if (rchw < (AW+2)'(count_r)) begin
          rd_en = 1'b1; rd_addr = rch; chave_nxt = 1'b1;
        end else chave_nxt = 1'b0;
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        cmp_ad = rd_d; cmp_ao = rd_o; cmp_bd = cd_r; cmp_bo = co_r;
        if (chave_r && cmp_lt) begin
          cd_nxt = rd_d; co_nxt = rd_o; cp_nxt = rch;
        end
        state_nxt = S_DNMV;
      end
      S_DNMV: begin
        cmp_ad = cd_r; cmp_ao = co_r; cmp_bd = wd_r; cmp_bo = wo_r;
        if (cmp_lt) begin
          wr_en = 1'b1; wr_addr = p_r; wr_d = cd_r; wr_o = co_r;
          p_nxt = cp_r; state_nxt = S_DNL;
        end else state_nxt = S_PLACE;
      end
      S_PLACE: begin
        wr_en = 1'b1;
        if (req_r == REQ_ADV) state_nxt = S_ADV;
        else begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_ADV: begin
        if (count_r == '0) begin
          ov_nxt = fired_r; state_nxt = S_IDLE;
        end else begin
          rd_en = 1'b1; rd_addr = '0; state_nxt = S_ADV2;
        end
      end
      S_ADV2: begin
        if (rd_d < now_r) begin
          // another one fires: the held word is not the last
          if (fired_r) begin
            ov_nxt = 1'b1; ol_nxt = 1'b0;
          end
          state_nxt = S_FIRE;
        end else begin
          ov_nxt = fired_r; state_nxt = S_IDLE;
        end
      end
      S_FIRE: begin
        os_nxt = ST_FIRED; oh_nxt = 6'(rd_o); odl_nxt = 32'(rd_d);
        fired_nxt = 1'b1;
        pos_raddr = rd_o;
        valid_nxt[rd_o] = 1'b0;
        count_nxt = count_r - 1'b1;
        p_nxt = '0;
        rd_en = 1'b1; rd_addr = AW'(count_r - 1'b1);
        state_nxt = S_TAIL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; now_r <= '0; valid_r <= '0;
      ov_r <= 1'b0; fired_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; now_r <= now_nxt;
      valid_r <= valid_nxt; ov_r <= ov_nxt; fired_r <= fired_nxt;
    end
    req_r <= req_nxt; dly_r <= dly_nxt; hreq_r <= hreq_nxt; tagin_r <= tagin_nxt;
    wd_r <= wd_nxt; wo_r <= wo_nxt; p_r <= p_nxt;
    cd_r <= cd_nxt; co_r <= co_nxt; cp_r <= cp_nxt; scan_r <= scan_nxt;
    chave_r <= chave_nxt; moved_r <= moved_nxt;
    ol_r <= ol_nxt; os_r <= os_nxt; oh_r <= oh_nxt; op_r <= op_nxt;
    odl_r <= odl_nxt;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("entry count overflow");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_ADV) |=> busy)
    else $error("advance not taken");
  a_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy) |-> ($countones(valid_r) == 32'(count_r)))
    else $error("valid bits disagree with count");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_FIRED))
    else $error("non-final word outside an advance");

endmodule
